@@ sv/gpc_pkg.sv @@
// ----------------------------------------------------------------------------
// gpc_pkg: shared constants and types for the genotype phase caller
// Fixed-point formats, arithmetic widths, queue sizing and the classified
// record handed from the front pipeline to the counter stage.
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

    // fixed-point format of the probabilities
    localparam int PROB_FRAC_BITS = 24;
    localparam int COUNT_BITS     = 32;

    // port widths fixed by the interface
    localparam int PROB_W    = 25;
    localparam int THR_W     = 25;
    localparam int OUT_CNT_W = 32;

    // error-rate mix constants
    localparam longint unsigned ONE_Q  = 64'd1 << PROB_FRAC_BITS;
    localparam longint unsigned ED_Q   = (ONE_Q + 64'd5000) / 64'd10000;
    localparam longint unsigned EE_Q   = ONE_Q - ED_Q;
    localparam longint unsigned HALF_Q = ONE_Q >> 1;
    localparam longint unsigned MIX_D  = EE_Q - ED_Q;

    // datapath widths
    localparam int SCORE_W  = PROB_FRAC_BITS + 1;
    localparam int PROD_W   = 2 * SCORE_W;
    localparam int G_W      = 2 * SCORE_W;
    localparam int SUM_W    = G_W + 1;
    localparam int SUM_HI_W = SUM_W - SCORE_W;
    localparam int PPL_W    = THR_W + SCORE_W;
    localparam int PPH_W    = THR_W + SUM_HI_W;
    localparam int CMP_W    = G_W + PROB_FRAC_BITS + THR_W;

    // score offsets: allele 0 falls with p, allele 1 rises with p
    localparam logic [PROD_W-1:0] BIAS0 = PROD_W'(ONE_Q * EE_Q + HALF_Q);
    localparam logic [PROD_W-1:0] BIAS1 = PROD_W'(ONE_Q * ED_Q + HALF_Q);

    // queue between front and back
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified result of one request
    typedef struct packed {
        logic       start;
        logic       decided;
        logic       allele_hap0;
        logic       allele_hap1;
        logic [1:0] add_decided;
        logic [1:0] add_examined;
    } gpc_rec_t;

endpackage

`default_nettype wire

@@ sv/gpc_front.sv @@
// ----------------------------------------------------------------------------
// gpc_front: request intake and scoring pipeline
// Accepts requests against queue credits, forms allele and pair scores,
// takes the heterozygote decision and the missing-genotype argmax, and pushes
// one classified record into the queue per request.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_start_of_pass,
    input  wire logic                        s_is_het,
    input  wire logic                        s_is_missing,
    input  wire logic [gpc_pkg::PROB_W-1:0]  s_prob_hap0,
    input  wire logic [gpc_pkg::PROB_W-1:0]  s_prob_hap1,
    input  wire logic [gpc_pkg::THR_W-1:0]   threshold,
    input  wire logic                        q_pop,
    output logic                             q_push,
    output gpc_pkg::gpc_rec_t                q_push_rec
);
    import gpc_pkg::*;

    localparam int NSTAGE = 6;
    localparam logic [SCORE_W-1:0] ONE_S = SCORE_W'(ONE_Q);
    localparam logic [SCORE_W-1:0] MIX_S = SCORE_W'(MIX_D);

    typedef struct packed {
        logic start;
        logic het;
        logic mis;
    } flags_t;

    logic                accept;
    logic [QCNT_W-1:0]   occ_reg, occ_next;
    logic [NSTAGE-1:0]   vld_reg;
    flags_t              flg_reg [NSTAGE];

    logic [SCORE_W-1:0]  p0_reg, p1_reg;
    logic [PROD_W-1:0]   pr0_reg, pr1_reg;
    logic [SCORE_W-1:0]  a0_reg, a1_reg, b0_reg, b1_reg;
    logic [G_W-1:0]      g_reg [4];
    logic [G_W-1:0]      diff_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                gt_reg;
    logic [1:0]          best_reg;
    logic [PPL_W-1:0]    pp_lo_reg;
    logic [PPH_W-1:0]    pp_hi_reg;
    logic [G_W-1:0]      diff6_reg;
    logic                gt6_reg;
    logic [1:0]          best6_reg;

    logic [SCORE_W-1:0]  p0_clamp, p1_clamp;
    logic [PROD_W-1:0]   x00, x01, x10, x11;
    logic [1:0]          best_c;
    logic [G_W-1:0]      best_v;
    logic [CMP_W-1:0]    lhs, rhs;
    logic                het_dec;

    // credits: requests in the pipeline plus entries in the queue
    assign accept  = s_valid && s_ready;
    assign s_ready = (occ_reg < QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        occ_next = occ_reg;
        case ({accept, q_pop})
            2'b10:   occ_next = occ_reg + QCNT_W'(1);
            2'b01:   occ_next = occ_reg - QCNT_W'(1);
            default: occ_next = occ_reg;
        endcase
    end

    // probabilities above one count as one
    assign p0_clamp = (64'(s_prob_hap0) > ONE_Q) ? ONE_S : SCORE_W'(s_prob_hap0);
    assign p1_clamp = (64'(s_prob_hap1) > ONE_Q) ? ONE_S : SCORE_W'(s_prob_hap1);

    // per-haplotype allele scores, rounded half up
    assign x00 = BIAS0 - pr0_reg;
    assign x01 = BIAS1 + pr0_reg;
    assign x10 = BIAS0 - pr1_reg;
    assign x11 = BIAS1 + pr1_reg;

    // argmax of the four pair scores, ties to the lowest index
    always_comb begin
        best_c = 2'd0;
        best_v = g_reg[0];
        if (g_reg[1] > best_v) begin
            best_c = 2'd1;
            best_v = g_reg[1];
        end
        if (g_reg[2] > best_v) begin
            best_c = 2'd2;
            best_v = g_reg[2];
        end
        if (g_reg[3] > best_v) begin
            best_c = 2'd3;
            best_v = g_reg[3];
        end
    end

    // gap test: |g01 - g10| * one against threshold * (g01 + g10)
    assign lhs     = CMP_W'(diff6_reg) << PROB_FRAC_BITS;
    assign rhs     = CMP_W'(pp_lo_reg) + (CMP_W'(pp_hi_reg) << SCORE_W);
    assign het_dec = flg_reg[NSTAGE-1].het && (lhs > rhs);

    // record assembly at the pipeline tail
    always_comb begin
        q_push                  = vld_reg[NSTAGE-1];
        q_push_rec.start        = flg_reg[NSTAGE-1].start;
        q_push_rec.decided      = het_dec || flg_reg[NSTAGE-1].mis;
        q_push_rec.allele_hap0  = 1'b0;
        q_push_rec.allele_hap1  = 1'b0;
        if (flg_reg[NSTAGE-1].mis) begin
            q_push_rec.allele_hap0 = best6_reg[1];
            q_push_rec.allele_hap1 = best6_reg[0];
        end else if (het_dec) begin
            q_push_rec.allele_hap0 = !gt6_reg;
            q_push_rec.allele_hap1 = gt6_reg;
        end
        q_push_rec.add_decided  = {1'b0, het_dec} + {1'b0, flg_reg[NSTAGE-1].mis};
        q_push_rec.add_examined = {1'b0, flg_reg[NSTAGE-1].het}
                                + {1'b0, flg_reg[NSTAGE-1].mis};
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
            vld_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            vld_reg <= {vld_reg[NSTAGE-2:0], accept};
        end
    end

    // scoring datapath, advances every cycle
    always_ff @(posedge aclk) begin
        flg_reg[0] <= '{start: s_start_of_pass, het: s_is_het, mis: s_is_missing};
        for (int i = 1; i < NSTAGE; i++) begin
            flg_reg[i] <= flg_reg[i-1];
        end
        p0_reg    <= p0_clamp;
        p1_reg    <= p1_clamp;
        pr0_reg   <= PROD_W'(p0_reg) * PROD_W'(MIX_S);
        pr1_reg   <= PROD_W'(p1_reg) * PROD_W'(MIX_S);
        a0_reg    <= x00[PROB_FRAC_BITS +: SCORE_W];
        a1_reg    <= x01[PROB_FRAC_BITS +: SCORE_W];
        b0_reg    <= x10[PROB_FRAC_BITS +: SCORE_W];
        b1_reg    <= x11[PROB_FRAC_BITS +: SCORE_W];
        g_reg[0]  <= G_W'(a0_reg) * G_W'(b0_reg);
        g_reg[1]  <= G_W'(a0_reg) * G_W'(b1_reg);
        g_reg[2]  <= G_W'(a1_reg) * G_W'(b0_reg);
        g_reg[3]  <= G_W'(a1_reg) * G_W'(b1_reg);
        gt_reg    <= (g_reg[1] > g_reg[2]);
        diff_reg  <= (g_reg[1] > g_reg[2]) ? (g_reg[1] - g_reg[2]) : (g_reg[2] - g_reg[1]);
        sum_reg   <= SUM_W'(g_reg[1]) + SUM_W'(g_reg[2]);
        best_reg  <= best_c;
        pp_lo_reg <= PPL_W'(threshold) * PPL_W'(sum_reg[SCORE_W-1:0]);
        pp_hi_reg <= PPH_W'(threshold) * PPH_W'(sum_reg[SUM_W-1:SCORE_W]);
        diff6_reg <= diff_reg;
        gt6_reg   <= gt_reg;
        best6_reg <= best_reg;
    end

    // credit accounting never exceeds the queue
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("front credit count above queue depth");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == QCNT_W'(QUEUE_DEPTH)) |-> !accept)
        else $error("request accepted without a free credit");

endmodule

`default_nettype wire

@@ sv/gpc_queue.sv @@
// ----------------------------------------------------------------------------
// gpc_queue: record queue between the scoring front and the counter back
// Small first-in first-out buffer; the front only pushes when it holds a
// credit, so it never overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire gpc_pkg::gpc_rec_t push_rec,
    input  wire logic              pop,
    output gpc_pkg::gpc_rec_t      head_rec,
    output logic                   empty
);
    import gpc_pkg::*;

    gpc_rec_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign head_rec = mem_reg[rd_ptr_reg];

    // pointer and fill count updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QCNT_W'(QUEUE_DEPTH)) |-> (!push || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ sv/gpc_back.sv @@
// ----------------------------------------------------------------------------
// gpc_back: counter update and result register
// Pops classified records, applies the start clear and the saturating tally
// increments, and holds each result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  wire gpc_pkg::gpc_rec_t             head_rec,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_decided,
    output logic                               m_allele_hap0,
    output logic                               m_allele_hap1,
    output logic [gpc_pkg::OUT_CNT_W-1:0]      m_phased_count,
    output logic [gpc_pkg::OUT_CNT_W-1:0]      m_total_count
);
    import gpc_pkg::*;

    localparam logic [COUNT_BITS:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    logic                   m_valid_reg;
    logic [COUNT_BITS-1:0]  dec_tally_reg, dec_tally_next;
    logic [COUNT_BITS-1:0]  exam_tally_reg, exam_tally_next;
    logic [COUNT_BITS-1:0]  dec_base, exam_base;
    logic [COUNT_BITS:0]    dec_sum, exam_sum;
    logic                   decided_reg, al0_reg, al1_reg;

    // take a record when the result register is free or being drained
    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    // start clear, then saturating add of up to two
    always_comb begin
        dec_base        = head_rec.start ? '0 : dec_tally_reg;
        exam_base       = head_rec.start ? '0 : exam_tally_reg;
        dec_sum         = {1'b0, dec_base} + (COUNT_BITS + 1)'(head_rec.add_decided);
        exam_sum        = {1'b0, exam_base} + (COUNT_BITS + 1)'(head_rec.add_examined);
        dec_tally_next  = (dec_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                        : dec_sum[COUNT_BITS-1:0];
        exam_tally_next = (exam_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                        : exam_sum[COUNT_BITS-1:0];
    end

    // tallies and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            dec_tally_reg  <= '0;
            exam_tally_reg <= '0;
        end else begin
            if (q_pop) begin
                m_valid_reg    <= 1'b1;
                dec_tally_reg  <= dec_tally_next;
                exam_tally_reg <= exam_tally_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            decided_reg <= head_rec.decided;
            al0_reg     <= head_rec.allele_hap0;
            al1_reg     <= head_rec.allele_hap1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_decided      = decided_reg;
    assign m_allele_hap0  = al0_reg;
    assign m_allele_hap1  = al1_reg;
    assign m_phased_count = OUT_CNT_W'(dec_tally_reg);
    assign m_total_count  = OUT_CNT_W'(exam_tally_reg);

    // without a start clear the tallies only grow or hold
    a_tally_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !head_rec.start) |=>
            (exam_tally_reg >= $past(exam_tally_reg)) &&
            (dec_tally_reg >= $past(dec_tally_reg)))
        else $error("tally decreased without start of pass");

endmodule

`default_nettype wire

@@ sv/genotype_phase_call.sv @@
// Path: an accepted request passes the six-stage scoring pipeline, then the
//   queue, then the result register.
// Throughput: one request per cycle; a 16-entry queue with credit-based intake
//   lets the front keep accepting while the sink stalls, until credits run out.
// Reset: synchronous, active low; clears the counters, the threshold register,
//   the queue and all valid state. No clearing sweep, ready right after reset.
// ----------------------------------------------------------------------------
// genotype_phase_call: top level of the genotype phase caller
// Holds the threshold register and joins the scoring front, the record queue
// and the counter back end.
// ----------------------------------------------------------------------------
`default_nettype none

module genotype_phase_call (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gpc_pkg::THR_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_start_of_pass,
    input  wire logic                          s_is_het,
    input  wire logic                          s_is_missing,
    input  wire logic [gpc_pkg::PROB_W-1:0]    s_prob_hap0,
    input  wire logic [gpc_pkg::PROB_W-1:0]    s_prob_hap1,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_decided,
    output logic                               m_allele_hap0,
    output logic                               m_allele_hap1,
    output logic [gpc_pkg::OUT_CNT_W-1:0]      m_phased_count,
    output logic [gpc_pkg::OUT_CNT_W-1:0]      m_total_count
);
    import gpc_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic              q_push, q_pop, q_empty;
    gpc_rec_t          q_push_rec, q_head_rec;

    // decision threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // scoring front
    gpc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_of_pass (s_start_of_pass),
        .s_is_het        (s_is_het),
        .s_is_missing    (s_is_missing),
        .s_prob_hap0     (s_prob_hap0),
        .s_prob_hap1     (s_prob_hap1),
        .threshold       (thr_reg),
        .q_pop           (q_pop),
        .q_push          (q_push),
        .q_push_rec      (q_push_rec)
    );

    // record queue
    gpc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .pop      (q_pop),
        .head_rec (q_head_rec),
        .empty    (q_empty)
    );

    // counters and result register
    gpc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .head_rec       (q_head_rec),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decided      (m_decided),
        .m_allele_hap0  (m_allele_hap0),
        .m_allele_hap1  (m_allele_hap1),
        .m_phased_count (m_phased_count),
        .m_total_count  (m_total_count)
    );

endmodule

`default_nettype wire

@@ tb/sv/genotype_phase_call_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// genotype_phase_call_checker: prediction and compare for the phase caller
// Watches the threshold port and both request and result channels, predicts
// the call and running counters of every accepted request and compares each
// accepted result, field by field, against the oldest pending prediction.
// ----------------------------------------------------------------------------

module genotype_phase_call_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gpc_pkg::THR_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_start_of_pass,
    input  logic                              s_is_het,
    input  logic                              s_is_missing,
    input  logic [gpc_pkg::PROB_W-1:0]        s_prob_hap0,
    input  logic [gpc_pkg::PROB_W-1:0]        s_prob_hap1,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_decided,
    input  logic                              m_allele_hap0,
    input  logic                              m_allele_hap1,
    input  logic [gpc_pkg::OUT_CNT_W-1:0]     m_phased_count,
    input  logic [gpc_pkg::OUT_CNT_W-1:0]     m_total_count,
    output int                                mismatch_count,
    output int                                outstanding
);

    typedef struct packed {
        logic                            decided;
        logic                            allele_hap0;
        logic                            allele_hap1;
        logic [gpc_pkg::OUT_CNT_W-1:0]   phased_count;
        logic [gpc_pkg::OUT_CNT_W-1:0]   total_count;
    } phase_call_t;

    // shadow copy of the threshold register and the two counters
    logic [gpc_pkg::THR_W-1:0]       threshold;
    logic [gpc_pkg::COUNT_BITS-1:0]  phased_tally;
    logic [gpc_pkg::COUNT_BITS-1:0]  examined_tally;
    phase_call_t                     expected_calls[$];
    int                              mismatches;

    // per-haplotype allele score, probability clamped to one, rounded half up
    function automatic longint unsigned allele_score(input logic [gpc_pkg::PROB_W-1:0] raw,
                                                     input bit carries_one);
        longint unsigned p;
        longint unsigned acc;
        p = raw;
        if (p > gpc_pkg::ONE_Q)
            p = gpc_pkg::ONE_Q;
        if (carries_one)
            acc = (gpc_pkg::ONE_Q - p) * gpc_pkg::ED_Q + p * gpc_pkg::EE_Q;
        else
            acc = (gpc_pkg::ONE_Q - p) * gpc_pkg::EE_Q + p * gpc_pkg::ED_Q;
        return (acc + gpc_pkg::HALF_Q) >> gpc_pkg::PROB_FRAC_BITS;
    endfunction

    function automatic logic [gpc_pkg::COUNT_BITS-1:0] bump(
        input logic [gpc_pkg::COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // expected call for one genotype request, advances the counters
    function automatic phase_call_t call_genotype(input logic start, input logic het,
                                                  input logic missing,
                                                  input logic [gpc_pkg::PROB_W-1:0] p0,
                                                  input logic [gpc_pkg::PROB_W-1:0] p1);
        longint unsigned h0_score[2];
        longint unsigned h1_score[2];
        longint unsigned pair[4];
        longint unsigned gap;
        longint unsigned pair_sum;
        logic [127:0]    gap_scaled;
        logic [127:0]    bound;
        int              best;
        phase_call_t     call;
        for (int a = 0; a < 2; a++) begin
            h0_score[a] = allele_score(p0, a[0]);
            h1_score[a] = allele_score(p1, a[0]);
        end
        for (int k = 0; k < 4; k++)
            pair[k] = h0_score[k / 2] * h1_score[k % 2];
        call = '0;

        if (start) begin
            phased_tally   = '0;
            examined_tally = '0;
        end

        // heterozygote: phase only when the normalized gap beats the threshold
        if (het) begin
            gap        = (pair[1] > pair[2]) ? pair[1] - pair[2] : pair[2] - pair[1];
            pair_sum   = pair[1] + pair[2];
            gap_scaled = 128'(gap) << gpc_pkg::PROB_FRAC_BITS;
            bound      = 128'(threshold) * 128'(pair_sum);
            if (gap_scaled > bound) begin
                call.decided     = 1'b1;
                call.allele_hap0 = !(pair[1] > pair[2]);
                call.allele_hap1 = (pair[1] > pair[2]);
                phased_tally     = bump(phased_tally);
            end
            examined_tally = bump(examined_tally);
        end

        // missing: most likely allele pair, ties to the lowest index
        if (missing) begin
            best = 0;
            for (int k = 1; k < 4; k++)
                if (pair[k] > pair[best])
                    best = k;
            call.decided     = 1'b1;
            call.allele_hap0 = best[1];
            call.allele_hap1 = best[0];
            phased_tally     = bump(phased_tally);
            examined_tally   = bump(examined_tally);
        end

        call.phased_count = phased_tally[gpc_pkg::OUT_CNT_W-1:0];
        call.total_count  = examined_tally[gpc_pkg::OUT_CNT_W-1:0];
        return call;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // track requests, threshold writes and results at each edge
    always @(posedge aclk) begin
        phase_call_t want;
        if (!aresetn) begin
            threshold      = '0;
            phased_tally   = '0;
            examined_tally = '0;
            expected_calls.delete();
        end else begin
            if (s_valid && s_ready)
                expected_calls.insert(expected_calls.size(),
                                      call_genotype(s_start_of_pass, s_is_het,
                                                    s_is_missing, s_prob_hap0,
                                                    s_prob_hap1));
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_calls.size() == 0) begin
                    $display("[%0t] result with no request pending: decided %0d, phased %0d",
                             $time, m_decided, m_phased_count);
                    mismatches++;
                end else begin
                    want = expected_calls.pop_front();
                    check_field("decided", want.decided, m_decided);
                    check_field("allele_hap0", want.allele_hap0, m_allele_hap0);
                    check_field("allele_hap1", want.allele_hap1, m_allele_hap1);
                    check_field("phased_count", want.phased_count, m_phased_count);
                    check_field("total_count", want.total_count, m_total_count);
                end
            end
        end
        mismatch_count <= mismatches;
        outstanding    <= expected_calls.size();
    end

endmodule

@@ tb/sv/genotype_phase_call_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// genotype_phase_call_tb: top-level testbench for the genotype phase caller
// Drives directed and random genotype requests under varying threshold
// settings and idle patterns on both channels; the checker beside the block
// predicts every result, and this module reports the final verdict.
// ----------------------------------------------------------------------------

module genotype_phase_call_tb;

    localparam int PROB_W          = gpc_pkg::PROB_W;
    localparam int THR_W           = gpc_pkg::THR_W;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_REQUESTS  = 90;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic [PROB_W-1:0] PROB_ZERO = '0;
    localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(gpc_pkg::ONE_Q);
    localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(gpc_pkg::ONE_Q >> 1);
    localparam logic [PROB_W-1:0] PROB_MAX  = '1;
    localparam logic [THR_W-1:0]  THR_ZERO  = '0;
    localparam logic [THR_W-1:0]  THR_ONE   = THR_W'(gpc_pkg::ONE_Q);
    localparam logic [THR_W-1:0]  THR_HALF  = THR_W'(gpc_pkg::ONE_Q >> 1);
    localparam logic [THR_W-1:0]  THR_MAX   = '1;

    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            cfg_wr_en       = 1'b0;
    logic [THR_W-1:0]                cfg_wr_data     = '0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic                            s_start_of_pass = 1'b0;
    logic                            s_is_het        = 1'b0;
    logic                            s_is_missing    = 1'b0;
    logic [PROB_W-1:0]               s_prob_hap0     = '0;
    logic [PROB_W-1:0]               s_prob_hap1     = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic                            m_decided;
    logic                            m_allele_hap0;
    logic                            m_allele_hap1;
    logic [gpc_pkg::OUT_CNT_W-1:0]   m_phased_count;
    logic [gpc_pkg::OUT_CNT_W-1:0]   m_total_count;

    int mismatch_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    genotype_phase_call u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_of_pass (s_start_of_pass),
        .s_is_het        (s_is_het),
        .s_is_missing    (s_is_missing),
        .s_prob_hap0     (s_prob_hap0),
        .s_prob_hap1     (s_prob_hap1),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decided       (m_decided),
        .m_allele_hap0   (m_allele_hap0),
        .m_allele_hap1   (m_allele_hap1),
        .m_phased_count  (m_phased_count),
        .m_total_count   (m_total_count)
    );

    genotype_phase_call_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_of_pass (s_start_of_pass),
        .s_is_het        (s_is_het),
        .s_is_missing    (s_is_missing),
        .s_prob_hap0     (s_prob_hap0),
        .s_prob_hap1     (s_prob_hap1),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decided       (m_decided),
        .m_allele_hap0   (m_allele_hap0),
        .m_allele_hap1   (m_allele_hap1),
        .m_phased_count  (m_phased_count),
        .m_total_count   (m_total_count),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one request, with random idle cycles in front, held until accepted
    task automatic send_genotype(input logic start, input logic het, input logic missing,
                                 input logic [PROB_W-1:0] p0, input logic [PROB_W-1:0] p1);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_start_of_pass <= start;
        s_is_het        <= het;
        s_is_missing    <= missing;
        s_prob_hap0     <= p0;
        s_prob_hap1     <= p1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop requesting and wait for every pending result
    task automatic drain;
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (outstanding != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // probabilities biased toward the edges, ties at one half and clamping
    function automatic logic [PROB_W-1:0] random_prob;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return PROB_ZERO;
        else if (sel < 12)
            return PROB_ONE;
        else if (sel < 16)
            return PROB_HALF;
        else if (sel < 24)
            return PROB_W'($urandom_range(PROB_MAX, PROB_ONE + 1));
        else
            return PROB_W'($urandom_range(0, PROB_ONE));
    endfunction

    task automatic random_genotype;
        logic              start;
        logic              het;
        logic              missing;
        logic [PROB_W-1:0] p0;
        logic [PROB_W-1:0] p1;
        int unsigned       kind;
        start   = ($urandom_range(0, 99) < 5);
        kind    = $urandom_range(0, 99);
        het     = (kind < 40) || (kind >= 65 && kind < 75);
        missing = (kind >= 40 && kind < 75);
        p0      = random_prob();
        p1      = ($urandom_range(0, 9) == 0) ? p0 : random_prob();
        send_genotype(start, het, missing, p0, p1);
    endtask

    initial begin
        logic [THR_W-1:0] threshold;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests at the reset threshold of zero
        send_idle_pct = 14;
        recv_idle_pct = 78;
        send_genotype(1'b1, 1'b1, 1'b0, PROB_ZERO, PROB_ONE);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_ONE, PROB_ZERO);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_W'(gpc_pkg::ONE_Q / 3),
                      PROB_W'(gpc_pkg::ONE_Q / 3));
        send_genotype(1'b0, 1'b1, 1'b0, PROB_ZERO, PROB_ZERO);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_ONE, PROB_W'(gpc_pkg::ONE_Q - 1));
        send_genotype(1'b0, 1'b0, 1'b1, PROB_HALF, PROB_HALF);
        send_genotype(1'b0, 1'b0, 1'b1, PROB_HALF, PROB_ZERO);
        send_genotype(1'b0, 1'b0, 1'b1, PROB_ZERO, PROB_HALF);
        send_genotype(1'b0, 1'b0, 1'b1, PROB_ONE, PROB_ONE);
        send_genotype(1'b0, 1'b0, 1'b1, PROB_ONE, PROB_ZERO);
        send_genotype(1'b0, 1'b1, 1'b1, PROB_ZERO, PROB_ONE);
        send_genotype(1'b0, 1'b1, 1'b1, PROB_W'(gpc_pkg::ONE_Q / 4),
                      PROB_W'(gpc_pkg::ONE_Q / 4));
        send_genotype(1'b0, 1'b0, 1'b0, PROB_MAX, PROB_MAX);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_MAX, PROB_ZERO);
        send_genotype(1'b0, 1'b0, 1'b1, PROB_W'(gpc_pkg::ONE_Q + 1), PROB_MAX);
        send_genotype(1'b1, 1'b0, 1'b0, PROB_HALF, PROB_ONE);
        send_genotype(1'b1, 1'b0, 1'b1, PROB_ZERO, PROB_ZERO);
        drain();

        // threshold of one: no heterozygote can be phased
        write_threshold(THR_ONE);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_ZERO, PROB_ONE);
        send_genotype(1'b0, 1'b1, 1'b0, PROB_ONE, PROB_ZERO);
        send_genotype(1'b0, 1'b1, 1'b1, PROB_ZERO, PROB_ONE);
        drain();

        // random phases, each with its own threshold and idle pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 14;
                recv_idle_pct = 78;
            end else if (ph < 4) begin
                send_idle_pct = 78;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:       threshold = THR_W'($urandom_range(0, THR_ONE));
                1:       threshold = THR_MAX;
                2:       threshold = THR_W'($urandom_range(1, 4096));
                3:       threshold = THR_ZERO;
                4:       threshold = THR_W'($urandom);
                default: threshold = THR_W'($urandom_range(THR_ONE >> 4, THR_HALF));
            endcase
            write_threshold(threshold);
            repeat (PHASE_REQUESTS) random_genotype();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
